@@ sv/gshbtb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshbtb_pkg
// Shared types and constants for the gshare predictor with branch target
// buffer: entry layout, request and branch kind codes, controller states.
// ----------------------------------------------------------------------------
package gshbtb_pkg;

	localparam int unsigned PC_W             = 64;
	localparam int unsigned DEF_BTB_ENTRIES  = 1024;
	localparam int unsigned DEF_PHT_ENTRIES  = 256;
	localparam int unsigned DEF_HISTORY_BITS = 8;
	localparam int unsigned CNT_W            = 2;

	localparam logic [PC_W-1:0]  INSTR_BYTES = 64'd4;
	localparam logic [CNT_W-1:0] CNT_MAX     = 2'd3;
	localparam logic [CNT_W-1:0] CNT_MIN     = 2'd0;

	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_UPDATE  = 1'b1;

	typedef enum logic [1:0] {
		KIND_COND   = 2'd0,
		KIND_UNCOND = 2'd1,
		KIND_OTHER  = 2'd2
	} branch_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic            valid;
		logic            cond;
		logic [PC_W-1:0] tag;
		logic [PC_W-1:0] target;
	} btb_entry_t;

endpackage

@@ sv/gshbtb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshbtb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module gshbtb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/gshare_predictor_with_btb_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb_unit
// gshare direction predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// Each request beat is one read-modify-write pass: on acceptance the BTB and counter
// memories are read at the slots given by the PC (and the PC xor global
// history for the counters); in the following cycle the read data is checked,
// and once the output register is free (not held by rsp_stall) the result is
// loaded into it and any counter or BTB entry written back. The next beat is
// taken only once that write-back is done: beats do not overlap in the single
// read-modify-write pass through the memories. A finished result may sit in the
// output register while the next beat is accepted. After reset a clearing pass
// zeroes both memories, one entry a cycle, across max(BTB_ENTRIES, PHT_ENTRIES)
// entries (1024 by default); no request is accepted until it ends.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb_unit #(
	parameter int unsigned BTB_ENTRIES  = gshbtb_pkg::DEF_BTB_ENTRIES,
	parameter int unsigned PHT_ENTRIES  = gshbtb_pkg::DEF_PHT_ENTRIES,
	parameter int unsigned HISTORY_BITS = gshbtb_pkg::DEF_HISTORY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  logic [gshbtb_pkg::PC_W-1:0] pc,
	input  logic                        advance_enable,
	input  logic [1:0]                  branch_kind,
	input  logic [gshbtb_pkg::PC_W-1:0] resolved_target,
	input  logic                        taken,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        pc_write,
	output logic [gshbtb_pkg::PC_W-1:0] next_pc,
	output logic                        verdict_valid,
	output logic                        prediction_correct,
	output logic                        flush
);

	import gshbtb_pkg::*;

	localparam int unsigned BTB_IDX_W = $clog2(BTB_ENTRIES);
	localparam int unsigned PHT_IDX_W = $clog2(PHT_ENTRIES);
	localparam int unsigned CLR_N     = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
	localparam int unsigned CLR_W     = $clog2(CLR_N);
	localparam int unsigned ENTRY_W   = $bits(btb_entry_t);

	ctrl_state_t state_q, state_d;
	logic [CLR_W-1:0]        clr_q;
	logic [HISTORY_BITS-1:0] hist_q;

	// request held for the execute cycle
	logic                  req_type_s1;
	logic [PC_W-1:0]       pc_s1;
	logic                  adv_s1;
	logic [1:0]            kind_s1;
	logic [PC_W-1:0]       target_s1;
	logic                  taken_s1;
	logic [BTB_IDX_W-1:0]  btb_idx_s1;
	logic [PHT_IDX_W-1:0]  pht_idx_s1;

	// output register
	logic            out_valid_q;
	logic            pc_write_q;
	logic [PC_W-1:0] next_pc_q;
	logic            verdict_q;
	logic            correct_q;
	logic            flush_q;

	logic                 accept;
	logic                 done;
	logic                 out_blocked;
	logic [BTB_IDX_W-1:0] btb_ridx;
	logic [PHT_IDX_W-1:0] pht_ridx;

	btb_entry_t           btb_rd, btb_wd;
	logic                 btb_we;
	logic [BTB_IDX_W-1:0] btb_waddr;
	logic [CNT_W-1:0]     pht_rd, pht_wd;
	logic                 pht_we;
	logic [PHT_IDX_W-1:0] pht_waddr;

	// execute-cycle decisions
	logic             hit;
	logic             train;
	logic             install;
	logic [CNT_W-1:0] cnt_new;
	logic             res_pc_write;
	logic [PC_W-1:0]  res_next_pc;
	logic             res_verdict;
	logic             res_correct;
	logic             res_flush;

	assign out_blocked = out_valid_q && rsp_stall;
	assign btb_ridx    = pc[BTB_IDX_W+1:2];
	assign pht_ridx    = pc[PHT_IDX_W+1:2] ^ PHT_IDX_W'(hist_q);

	// ---------------- controller ----------------
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		accept    = 1'b0;
		done      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					accept  = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_blocked) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// ---------------- request capture ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			pc_s1       <= pc;
			adv_s1      <= advance_enable;
			kind_s1     <= branch_kind;
			target_s1   <= resolved_target;
			taken_s1    <= taken;
			btb_idx_s1  <= btb_ridx;
			pht_idx_s1  <= pht_ridx;
		end
	end

	// ---------------- memories ----------------
	gshbtb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (BTB_ENTRIES)
	) u_btb_ram (
		.clk   (clk),
		.we    (btb_we),
		.waddr (btb_waddr),
		.wdata (btb_wd),
		.re    (accept),
		.raddr (btb_ridx),
		.rdata (btb_rd)
	);

	gshbtb_ram #(
		.WIDTH (CNT_W),
		.DEPTH (PHT_ENTRIES)
	) u_pht_ram (
		.clk   (clk),
		.we    (pht_we),
		.waddr (pht_waddr),
		.wdata (pht_wd),
		.re    (accept),
		.raddr (pht_ridx),
		.rdata (pht_rd)
	);

	// ---------------- execute ----------------
	always_comb begin
		hit     = btb_rd.valid && (btb_rd.tag == pc_s1);
		train   = (req_type_s1 == REQ_UPDATE) && hit && btb_rd.cond;
		install = (req_type_s1 == REQ_UPDATE) && taken_s1 && !hit;

		// saturating 2-bit counter
		cnt_new = pht_rd;
		if (taken_s1) begin
			if (pht_rd != CNT_MAX) begin
				cnt_new = pht_rd + 1'b1;
			end
		end else begin
			if (pht_rd != CNT_MIN) begin
				cnt_new = pht_rd - 1'b1;
			end
		end

		res_pc_write = 1'b0;
		res_next_pc  = '0;
		res_verdict  = 1'b0;
		res_correct  = 1'b0;
		res_flush    = 1'b0;
		if (req_type_s1 == REQ_PREDICT) begin
			if (hit && (!btb_rd.cond || pht_rd[1])) begin
				res_pc_write = 1'b1;
				res_next_pc  = btb_rd.target;
			end else if (adv_s1) begin
				res_pc_write = 1'b1;
				res_next_pc  = pc_s1 + INSTR_BYTES;
			end
		end else if (train) begin
			res_verdict = 1'b1;
			res_correct = (pht_rd[1] == taken_s1);
			res_flush   = (pht_rd[1] != taken_s1);
		end else if (install && (kind_s1 == KIND_COND)) begin
			// freshly installed conditional branch counts as a mispredict
			res_verdict = 1'b1;
			res_flush   = 1'b1;
		end

		btb_wd.valid  = 1'b1;
		btb_wd.cond   = (kind_s1 == KIND_COND);
		btb_wd.tag    = pc_s1;
		btb_wd.target = target_s1;
		btb_waddr     = btb_idx_s1;
		btb_we        = done && install;
		pht_wd        = cnt_new;
		pht_waddr     = pht_idx_s1;
		pht_we        = done && train;

		if (state_q == ST_CLEAR) begin
			btb_wd    = '0;
			btb_waddr = clr_q[BTB_IDX_W-1:0];
			btb_we    = 1'b1;
			pht_wd    = '0;
			pht_waddr = clr_q[PHT_IDX_W-1:0];
			pht_we    = 1'b1;
		end
	end

	// global history shifts on every update that is not an unconditional branch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (done && (req_type_s1 == REQ_UPDATE) && (kind_s1 != KIND_UNCOND)) begin
			hist_q <= {hist_q[HISTORY_BITS-2:0], taken_s1};
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pc_write_q <= res_pc_write;
			next_pc_q  <= res_next_pc;
			verdict_q  <= res_verdict;
			correct_q  <= res_correct;
			flush_q    <= res_flush;
		end
	end

	assign rsp_valid          = out_valid_q;
	assign pc_write           = pc_write_q;
	assign next_pc            = next_pc_q;
	assign verdict_valid      = verdict_q;
	assign prediction_correct = correct_q;
	assign flush              = flush_q;

endmodule
